// ----- rtl/circular_free_list_allocator_unit_macros.svh -----
// Assertion macros used by the allocator's checker file.
`ifndef CIRCULAR_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define CIRCULAR_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define CFLA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define CFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cfla_pkg.sv -----
// Shared types and constants of the circular free-list allocator.
`default_nettype none

package cfla_pkg;

  // Fixed field widths of the command and result ports.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 11;

  // Reset value of the slot count register.
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

  // Action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT      = 2'd0,
    ACT_RSV_HEAD  = 2'd1,
    ACT_RELEASE   = 2'd2,
    ACT_RSV_NAMED = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_REL_FREE = 3'd2,
    ST_IN_USE   = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SWEEP  = 3'd1,
    S_LOOK   = 3'd2,
    S_UPDATE = 3'd3,
    S_LINK   = 3'd4
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch a new command
    logic sweep;   // write one slot of the init sweep
    logic look;    // read the link and flag tables
    logic update;  // decide and do the first set of writes
    logic link;    // second link writes of a release
    logic finish;  // present the result in the next cycle
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // the sweep is at the last slot
    logic need_link;   // the release needs a second write cycle
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/circular_free_list_allocator_unit.sv -----
// Top level of the circular free-list slot allocator.
`default_nettype none

// Usage:
// A command (action_i, slot_index_i) transfers at a rising edge with start_i
// high and busy_o low. Actions: init chain, reserve head, release slot and
// reserve named slot. Each command gives exactly one result: granted_slot_o,
// status_o and free_slots_o are valid for the single cycle in which done_o is
// high. The receiver cannot stall, so the result must be taken in that cycle.
// Reserve head, reserve named and failed commands pass through a
// registered read of the link tables (look) and then the table writes
// (update); a release that links into a non-empty chain adds a second
// set of link writes (link). Init sweeps every one of the SLOTS table
// entries, one per cycle. done_o is registered from the last step of each
// command and rises together with the fall of busy_o, so the next command
// can transfer at the edge that takes the result.
// The slot count register is written over the cfg channel (cfg_ready_o is
// always high) and takes effect at the next command; write it only while
// the unit is idle. Reset empties the chain, clears the free count and loads
// a slot count of 1024; the link tables hold nothing until the first init.
module circular_free_list_allocator_unit #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [cfla_pkg::ACTION_W-1:0] action_i,
  input  wire logic [cfla_pkg::INDEX_W-1:0]  slot_index_i,
  output logic                               done_o,
  output logic      [cfla_pkg::INDEX_W-1:0]  granted_slot_o,
  output logic      [cfla_pkg::STATUS_W-1:0] status_o,
  output logic      [cfla_pkg::COUNT_W-1:0]  free_slots_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cfla_pkg::COUNT_W-1:0]  cfg_data_i
);

  cfla_pkg::cmd_t cmd;
  cfla_pkg::sts_t sts;

  // Sequencing of each command.
  cfla_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Tables, anchor, counters and result registers.
  cfla_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .slot_index_i   (slot_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .granted_slot_o (granted_slot_o),
    .status_o       (status_o),
    .free_slots_o   (free_slots_o),
    .done_o         (done_o)
  );

  // The count register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/cfla_ram.sv -----
// Generic memory with one write port and one registered read port.
`default_nettype none

module cfla_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cfla_ctrl.sv -----
// Controller state machine of the circular free-list allocator.
`default_nettype none

module cfla_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [1:0]        action_i,
  input  wire cfla_pkg::sts_t    sts_i,
  output cfla_pkg::cmd_t         cmd_o,
  output logic                   busy_o
);

  cfla_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfla_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      cfla_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (cfla_pkg::action_e'(action_i) == cfla_pkg::ACT_INIT) begin
            state_d = cfla_pkg::S_SWEEP;
          end else begin
            state_d = cfla_pkg::S_LOOK;
          end
        end
      end
      cfla_pkg::S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.finish = 1'b1;
          state_d      = cfla_pkg::S_IDLE;
        end
      end
      cfla_pkg::S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = cfla_pkg::S_UPDATE;
      end
      cfla_pkg::S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.need_link) begin
          state_d = cfla_pkg::S_LINK;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = cfla_pkg::S_IDLE;
        end
      end
      cfla_pkg::S_LINK: begin
        cmd_o.link   = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = cfla_pkg::S_IDLE;
      end
      default: begin
        state_d = cfla_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != cfla_pkg::S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/cfla_dp.sv -----
// Datapath of the circular free-list allocator: link tables, anchor and counters.
`default_nettype none

module cfla_dp #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire cfla_pkg::cmd_t                     cmd_i,
  output cfla_pkg::sts_t                          sts_o,
  input  wire logic [cfla_pkg::ACTION_W-1:0]      action_i,
  input  wire logic [cfla_pkg::INDEX_W-1:0]       slot_index_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [cfla_pkg::COUNT_W-1:0]       cfg_data_i,
  output logic      [cfla_pkg::INDEX_W-1:0]       granted_slot_o,
  output logic      [cfla_pkg::STATUS_W-1:0]      status_o,
  output logic      [cfla_pkg::COUNT_W-1:0]       free_slots_o,
  output logic                                    done_o
);

  localparam int unsigned LW = $clog2(SLOTS);
  localparam int unsigned CW = ($clog2(SLOTS + 1) > cfla_pkg::COUNT_W) ?
                               $clog2(SLOTS + 1) : cfla_pkg::COUNT_W;

  // Control state.
  logic [cfla_pkg::COUNT_W-1:0] slot_count_q;
  logic [LW-1:0]                head_q, head_d;
  logic                         hvalid_q, hvalid_d;
  logic [CW-1:0]                free_q, free_d;
  logic                         done_q;

  // Latched command and sweep position.
  cfla_pkg::action_e            act_q;
  logic [cfla_pkg::INDEX_W-1:0] s_q;
  logic [CW-1:0]                n_q;
  logic [LW-1:0]                i_q;

  // Result registers.
  logic [cfla_pkg::INDEX_W-1:0] gr_q, gr_d;
  cfla_pkg::status_e            st_q, st_d;
  logic [cfla_pkg::COUNT_W-1:0] fs_q, fs_d;

  // Table ports.
  logic          prev_we, next_we, busy_we;
  logic [LW-1:0] prev_wa, next_wa, busy_wa;
  logic [LW-1:0] prev_wd, next_wd;
  logic          busy_wd;
  logic [LW-1:0] link_ra;
  logic [LW-1:0] prev_rd, next_rd;
  logic          busy_rd;

  // Derived values.
  logic [CW-1:0] eff_n;
  logic [LW-1:0] s_idx;
  logic          in_range;
  logic [CW-1:0] i_ext, i_plus;
  logic [CW-1:0] free_dec, free_inc;

  // Slot count clamped to the supported range.
  always_comb begin
    if (CW'(slot_count_q) < CW'(2)) begin
      eff_n = CW'(2);
    end else if (CW'(slot_count_q) > CW'(SLOTS)) begin
      eff_n = CW'(SLOTS);
    end else begin
      eff_n = CW'(slot_count_q);
    end
  end

  assign s_idx    = LW'(s_q);
  assign in_range = (CW'(s_q) < n_q);
  assign i_ext    = CW'(i_q);
  assign i_plus   = i_ext + CW'(1);
  assign free_dec = (free_q != '0) ? free_q - CW'(1) : free_q;
  assign free_inc = (free_q < CW'(SLOTS)) ? free_q + CW'(1) : free_q;

  // Link reads address the named slot or the anchor; flag reads the named slot.
  assign link_ra = (act_q == cfla_pkg::ACT_RSV_NAMED) ? s_idx : head_q;

  assign sts_o.sweep_last = (i_q == LW'(SLOTS - 1));
  assign sts_o.need_link  = (act_q == cfla_pkg::ACT_RELEASE) && in_range &&
                            busy_rd && hvalid_q;

  // Table writes, anchor, counter and result for each step.
  always_comb begin
    prev_we  = 1'b0;
    next_we  = 1'b0;
    busy_we  = 1'b0;
    prev_wa  = '0;
    next_wa  = '0;
    busy_wa  = '0;
    prev_wd  = '0;
    next_wd  = '0;
    busy_wd  = 1'b0;
    head_d   = head_q;
    hvalid_d = hvalid_q;
    free_d   = free_q;
    gr_d     = gr_q;
    st_d     = st_q;
    fs_d     = fs_q;

    if (cmd_i.sweep) begin
      // Init: clear every flag, and chain the counted slots in index order.
      busy_we = 1'b1;
      busy_wa = i_q;
      busy_wd = 1'b0;
      if (i_ext < n_q) begin
        prev_we = 1'b1;
        prev_wa = i_q;
        prev_wd = (i_q == '0) ? LW'(n_q - CW'(1)) : i_q - LW'(1);
        next_we = 1'b1;
        next_wa = i_q;
        next_wd = (i_plus == n_q) ? '0 : LW'(i_plus);
      end
      if (sts_o.sweep_last) begin
        head_d   = '0;
        hvalid_d = 1'b1;
        free_d   = n_q;
        gr_d     = '0;
        st_d     = cfla_pkg::ST_OK;
        fs_d     = cfla_pkg::COUNT_W'(n_q);
      end
    end

    if (cmd_i.update) begin
      gr_d = '0;
      st_d = cfla_pkg::ST_OK;
      case (act_q)
        cfla_pkg::ACT_RSV_HEAD: begin
          if (!hvalid_q) begin
            st_d = cfla_pkg::ST_NO_FREE;
          end else begin
            // Unlink the anchor slot; a lone slot empties the chain.
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
            busy_we = 1'b1;
            busy_wa = head_q;
            busy_wd = 1'b1;
            if (next_rd == head_q) begin
              hvalid_d = 1'b0;
              head_d   = '0;
            end else begin
              head_d = next_rd;
            end
            free_d = free_dec;
            gr_d   = cfla_pkg::INDEX_W'(head_q);
          end
        end
        cfla_pkg::ACT_RELEASE: begin
          if (!in_range) begin
            st_d = cfla_pkg::ST_RANGE;
          end else if (!busy_rd) begin
            st_d = cfla_pkg::ST_REL_FREE;
          end else begin
            busy_we = 1'b1;
            busy_wa = s_idx;
            busy_wd = 1'b0;
            prev_we = 1'b1;
            prev_wa = s_idx;
            next_we = 1'b1;
            next_wa = s_idx;
            if (!hvalid_q) begin
              // The slot forms a chain of its own.
              prev_wd  = s_idx;
              next_wd  = s_idx;
              head_d   = s_idx;
              hvalid_d = 1'b1;
            end else begin
              // Slot goes between the last slot and the anchor.
              prev_wd = prev_rd;
              next_wd = head_q;
            end
            free_d = free_inc;
          end
        end
        cfla_pkg::ACT_RSV_NAMED: begin
          if (!in_range) begin
            st_d = cfla_pkg::ST_RANGE;
          end else if (busy_rd) begin
            st_d = cfla_pkg::ST_IN_USE;
          end else begin
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
            busy_we = 1'b1;
            busy_wa = s_idx;
            busy_wd = 1'b1;
            if (hvalid_q && (head_q == s_idx)) begin
              if (next_rd == s_idx) begin
                hvalid_d = 1'b0;
                head_d   = '0;
              end else begin
                head_d = next_rd;
              end
            end
            free_d = free_dec;
            gr_d   = s_q;
          end
        end
        default: begin
          st_d = cfla_pkg::ST_OK;
        end
      endcase
      fs_d = cfla_pkg::COUNT_W'(free_d);
    end

    if (cmd_i.link) begin
      // Second half of a release: anchor and last slot point at the new slot.
      prev_we = 1'b1;
      prev_wa = head_q;
      prev_wd = s_idx;
      next_we = 1'b1;
      next_wa = prev_rd;
      next_wd = s_idx;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= cfla_pkg::SLOT_COUNT_RESET;
      head_q       <= '0;
      hvalid_q     <= 1'b0;
      free_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        slot_count_q <= cfg_data_i;
      end
      head_q   <= head_d;
      hvalid_q <= hvalid_d;
      free_q   <= free_d;
      done_q   <= cmd_i.finish;
    end
  end

  // Command capture, sweep position and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= cfla_pkg::action_e'(action_i);
      s_q   <= slot_index_i;
      n_q   <= eff_n;
      i_q   <= '0;
    end else if (cmd_i.sweep) begin
      i_q <= i_q + LW'(1);
    end
    gr_q <= gr_d;
    st_q <= st_d;
    fs_q <= fs_d;
  end

  // Predecessor, successor and in-use tables.
  cfla_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_wa),
    .wdata_i (prev_wd),
    .re_i    (cmd_i.look),
    .raddr_i (link_ra),
    .rdata_o (prev_rd)
  );

  cfla_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_wa),
    .wdata_i (next_wd),
    .re_i    (cmd_i.look),
    .raddr_i (link_ra),
    .rdata_o (next_rd)
  );

  cfla_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (busy_we),
    .waddr_i (busy_wa),
    .wdata_i (busy_wd),
    .re_i    (cmd_i.look),
    .raddr_i (s_idx),
    .rdata_o (busy_rd)
  );

  assign granted_slot_o = gr_q;
  assign status_o       = st_q;
  assign free_slots_o   = fs_q;
  assign done_o         = done_q;

endmodule

`default_nettype wire

// ----- rtl/cfla_checker.sv -----
// Port-level assertions for the circular free-list allocator, bound to the top level.
`default_nettype none

`include "circular_free_list_allocator_unit_macros.svh"

module cfla_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic                          done_o,
  input wire logic [cfla_pkg::INDEX_W-1:0]  granted_slot_o,
  input wire logic [cfla_pkg::STATUS_W-1:0] status_o,
  input wire logic [cfla_pkg::COUNT_W-1:0]  free_slots_o
);

  logic fail_w;
  logic empty_w;

  // Strobed results that report a failure or an empty chain.
  assign fail_w  = done_o && (status_o != cfla_pkg::ST_OK);
  assign empty_w = done_o && (status_o == cfla_pkg::ST_NO_FREE);

  // A command transfer always makes the unit busy in the next cycle.
  `CFLA_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "transfer did not start work")

  // A result only follows a cycle of work.
  `CFLA_ASSERT_IMPLY(a_done_after_busy, done_o, $past(busy_o), "result without work")

  // A failed command grants no slot.
  `CFLA_ASSERT_IMPLY(a_fail_no_grant, fail_w, granted_slot_o == '0, "failure granted a slot")

  // Reporting an empty chain goes with a zero free count.
  `CFLA_ASSERT_IMPLY(a_empty_count, empty_w, free_slots_o == '0, "empty chain with free slots")

endmodule

bind circular_free_list_allocator_unit cfla_checker u_cfla_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .granted_slot_o (granted_slot_o),
  .status_o       (status_o),
  .free_slots_o   (free_slots_o)
);

`default_nettype wire
